### rtl/gst_pkg.sv
// Shared types and codes for the GPU resource and scanout table.
package gst_pkg;

  localparam int DIM_MAX_W = 16;  // widest stored dimension over the parameter range
  localparam int REPORT_W  = 15;
  localparam int CLIP_XY_W = 14;
  localparam int CLIP_WH_W = 15;

  localparam logic [3:0] CMD_INFO     = 4'd0;
  localparam logic [3:0] CMD_CREATE   = 4'd1;
  localparam logic [3:0] CMD_UNREF    = 4'd2;
  localparam logic [3:0] CMD_SCANOUT  = 4'd3;
  localparam logic [3:0] CMD_FLUSH    = 4'd4;
  localparam logic [3:0] CMD_TRANSFER = 4'd5;
  localparam logic [3:0] CMD_ATTACH   = 4'd6;
  localparam logic [3:0] CMD_DETACH   = 4'd7;
  localparam logic [3:0] CMD_RESET    = 4'd8;

  localparam logic [2:0] RSP_OK       = 3'd0;
  localparam logic [2:0] RSP_INFO     = 3'd1;
  localparam logic [2:0] RSP_UNSPEC   = 3'd2;
  localparam logic [2:0] RSP_BADPARAM = 3'd3;
  localparam logic [2:0] RSP_BADRES   = 3'd4;
  localparam logic [2:0] RSP_FULL     = 3'd5;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_PARTIAL = 2'd1;
  localparam logic [1:0] KIND_FULL    = 2'd2;
  localparam logic [1:0] KIND_XFER    = 2'd3;

  localparam logic [1:0] EV_NONE      = 2'd0;
  localparam logic [1:0] EV_DISABLED  = 2'd1;
  localparam logic [1:0] EV_ENABLED   = 2'd2;

  localparam logic REG_DISPLAY_WIDTH  = 1'b0;
  localparam logic REG_DISPLAY_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    CL_INFO, CL_BADPARAM, CL_UNSPEC, CL_CREATE, CL_UNREF, CL_SCAN_OFF,
    CL_SCAN_ON, CL_FLUSH, CL_XFER, CL_ATTACH, CL_DETACH, CL_RESET
  } gst_class_t;

  typedef struct packed {
    gst_class_t            cls;
    logic                  fence;
    logic                  cnt_over;
    logic [31:0]           id;
    logic [DIM_MAX_W-1:0]  dim_w;
    logic [DIM_MAX_W-1:0]  dim_h;
    logic [31:0]           x;
    logic [31:0]           y;
    logic [31:0]           w;
    logic [31:0]           h;
  } gst_item_t;

  typedef struct packed {
    logic      vld;
    gst_item_t item;
  } gst_queue_t;

  typedef struct packed {
    logic [2:0]           response;
    logic                 fence;
    logic [REPORT_W-1:0]  rep_w;
    logic [REPORT_W-1:0]  rep_h;
    logic [CLIP_XY_W-1:0] cx;
    logic [CLIP_XY_W-1:0] cy;
    logic [CLIP_WH_W-1:0] cw;
    logic [CLIP_WH_W-1:0] ch;
    logic [1:0]           kind;
    logic [1:0]           ev;
  } gst_result_t;

endpackage

### rtl/gpu_resource_scanout_table_top.sv
// Top level of the GPU 2D resource and scanout table.
// Info, reset, rejected and unknown commands skip the table walk and go straight to the
//   result register; table commands walk the resource RAM one entry per cycle through
//   its single read port, stopping on a hit.
// Throughput: one command at a time in the table engine; a 2-entry queue in front.
// Reset (rst_n low, synchronous): table empty, scanout unbound, display 1024 x 768.
module gpu_resource_scanout_table_top import gst_pkg::*; #(
  parameter int TABLE_ENTRIES       = 64,
  parameter int MAX_DIMENSION       = 16384,
  parameter int MAX_BACKING_ENTRIES = 16384
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // command channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [3:0]           in_command,
  input  logic [31:0]          in_resource_id,
  input  logic [31:0]          in_res_width,
  input  logic [31:0]          in_res_height,
  input  logic [31:0]          in_rect_x,
  input  logic [31:0]          in_rect_y,
  input  logic [31:0]          in_rect_w,
  input  logic [31:0]          in_rect_h,
  input  logic [31:0]          in_scanout_index,
  input  logic [31:0]          in_entry_count,
  input  logic                 in_fence_requested,
  input  logic                 in_request_short,
  // response channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_response,
  output logic                 out_fence_echo,
  output logic [REPORT_W-1:0]  out_report_width,
  output logic [REPORT_W-1:0]  out_report_height,
  output logic [CLIP_XY_W-1:0] out_clip_x,
  output logic [CLIP_XY_W-1:0] out_clip_y,
  output logic [CLIP_WH_W-1:0] out_clip_w,
  output logic [CLIP_WH_W-1:0] out_clip_h,
  output logic [1:0]           out_region_kind,
  output logic [1:0]           out_scanout_event,
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [REPORT_W-1:0] disp_w_r, disp_h_r;
  logic                cfg_wr;
  gst_queue_t          q;
  logic                q_take;
  gst_result_t         res;

  // Display size registers; a write lands on the access phase. Index is paddr[2].
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_w_r <= REPORT_W'(1024);
      disp_h_r <= REPORT_W'(768);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_DISPLAY_WIDTH)  disp_w_r <= pwdata[REPORT_W-1:0];
      if (paddr[2] == REG_DISPLAY_HEIGHT) disp_h_r <= pwdata[REPORT_W-1:0];
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DISPLAY_WIDTH:  prdata = 32'(disp_w_r);
      REG_DISPLAY_HEIGHT: prdata = 32'(disp_h_r);
      default:            prdata = '0;
    endcase
  end

  // Front: classify each command and queue it.
  gst_front #(
    .MAX_DIMENSION       (MAX_DIMENSION),
    .MAX_BACKING_ENTRIES (MAX_BACKING_ENTRIES)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_resource_id     (in_resource_id),
    .in_res_width       (in_res_width),
    .in_res_height      (in_res_height),
    .in_rect_x          (in_rect_x),
    .in_rect_y          (in_rect_y),
    .in_rect_w          (in_rect_w),
    .in_rect_h          (in_rect_h),
    .in_scanout_index   (in_scanout_index),
    .in_entry_count     (in_entry_count),
    .in_fence_requested (in_fence_requested),
    .in_request_short   (in_request_short),
    .q                  (q),
    .q_take             (q_take)
  );

  // Back: table lookup, clipping, scanout tracking and the result register.
  gst_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q         (q),
    .q_take    (q_take),
    .disp_w    (disp_w_r),
    .disp_h    (disp_h_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_response      = res.response;
  assign out_fence_echo    = res.fence;
  assign out_report_width  = res.rep_w;
  assign out_report_height = res.rep_h;
  assign out_clip_x        = res.cx;
  assign out_clip_y        = res.cy;
  assign out_clip_w        = res.cw;
  assign out_clip_h        = res.ch;
  assign out_region_kind   = res.kind;
  assign out_scanout_event = res.ev;

endmodule

### rtl/gst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/gst_front.sv
// Command classifier and two-entry queue toward the table engine.
module gst_front import gst_pkg::*; #(
  parameter int MAX_DIMENSION       = 16384,
  parameter int MAX_BACKING_ENTRIES = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_command,
  input  logic [31:0] in_resource_id,
  input  logic [31:0] in_res_width,
  input  logic [31:0] in_res_height,
  input  logic [31:0] in_rect_x,
  input  logic [31:0] in_rect_y,
  input  logic [31:0] in_rect_w,
  input  logic [31:0] in_rect_h,
  input  logic [31:0] in_scanout_index,
  input  logic [31:0] in_entry_count,
  input  logic        in_fence_requested,
  input  logic        in_request_short,
  output gst_queue_t  q,
  input  logic        q_take
);

  gst_item_t  item;
  gst_class_t cls;
  logic       size_bad;
  gst_item_t  mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  always_comb begin
    size_bad = (in_res_width == '0) || (in_res_height == '0) ||
               (in_res_width > 32'(MAX_DIMENSION)) ||
               (in_res_height > 32'(MAX_DIMENSION));
    if (in_command inside {[CMD_CREATE:CMD_DETACH]} && in_request_short) begin
      cls = CL_BADPARAM;
    end else begin
      case (in_command)
        CMD_INFO:     cls = CL_INFO;
        CMD_CREATE:   cls = (in_resource_id == '0 || size_bad) ? CL_BADPARAM : CL_CREATE;
        CMD_UNREF:    cls = CL_UNREF;
        CMD_SCANOUT: begin
          if (in_scanout_index != '0)    cls = CL_BADPARAM;
          else if (in_resource_id == '0) cls = CL_SCAN_OFF;
          else                           cls = CL_SCAN_ON;
        end
        CMD_FLUSH:    cls = CL_FLUSH;
        CMD_TRANSFER: cls = CL_XFER;
        CMD_ATTACH:   cls = CL_ATTACH;
        CMD_DETACH:   cls = CL_DETACH;
        CMD_RESET:    cls = CL_RESET;
        default:      cls = CL_UNSPEC;
      endcase
    end
    item.cls      = cls;
    item.fence    = in_fence_requested;
    item.cnt_over = in_entry_count > 32'(MAX_BACKING_ENTRIES);
    item.id       = in_resource_id;
    item.dim_w    = in_res_width[DIM_MAX_W-1:0];
    item.dim_h    = in_res_height[DIM_MAX_W-1:0];
    item.x        = in_rect_x;
    item.y        = in_rect_y;
    item.w        = in_rect_w;
    item.h        = in_rect_h;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = q.vld && q_take;
  assign q.vld    = (cnt_r != 2'd0);
  assign q.item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

### rtl/gst_back.sv
// Table engine: sequential lookup, clipping, state update and result register.
module gst_back import gst_pkg::*; #(
  parameter int TABLE_ENTRIES = 64,
  parameter int MAX_DIMENSION = 16384
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gst_queue_t          q,
  output logic                q_take,
  input  logic [REPORT_W-1:0] disp_w,
  input  logic [REPORT_W-1:0] disp_h,
  output logic                out_valid,
  input  logic                out_stall,
  output gst_result_t         res
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int DW = $clog2(MAX_DIMENSION + 1);
  localparam int RW = 32 + 2 * DW;
  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_CLIP, S_DONE} state_t;

  state_t                   state_r, state_nxt;
  gst_item_t                item_r, item_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [IW-1:0]            scan_idx_r, scan_idx_nxt, chk_idx_r, chk_idx_nxt;
  logic                     issue_r, issue_nxt, chk_v_r, chk_v_nxt;
  logic                     hit_r, hit_nxt, free_r, free_nxt;
  logic [IW-1:0]            hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt;
  logic [DW-1:0]            hit_w_r, hit_w_nxt, hit_h_r, hit_h_nxt;
  logic [31:0]              so_res_r, so_res_nxt;
  logic [DW-1:0]            so_w_r, so_w_nxt, so_h_r, so_h_nxt;
  logic [DW-1:0]            cw_r, cw_nxt, ch_r, ch_nxt;
  logic                     in_rng_r, in_rng_nxt;
  logic                     out_valid_r, out_valid_nxt;
  gst_result_t              res_r, res_nxt;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata, ram_rdata;
  logic [31:0]   rd_id;
  logic [DW-1:0] rd_w, rd_h;
  logic          match, is_last, needs_scan, can_load;
  logic [32:0]   ew, eh, sum_x, sum_y;
  state_t        after_scan;

  gst_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  assign {rd_id, rd_w, rd_h} = ram_rdata;
  assign q_take    = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign res       = res_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    valid_nxt     = valid_r;
    scan_idx_nxt  = scan_idx_r;
    chk_idx_nxt   = chk_idx_r;
    issue_nxt     = issue_r;
    chk_v_nxt     = 1'b0;
    hit_nxt       = hit_r;
    free_nxt      = free_r;
    hit_idx_nxt   = hit_idx_r;
    free_idx_nxt  = free_idx_r;
    hit_w_nxt     = hit_w_r;
    hit_h_nxt     = hit_h_r;
    so_res_nxt    = so_res_r;
    so_w_nxt      = so_w_r;
    so_h_nxt      = so_h_r;
    cw_nxt        = cw_r;
    ch_nxt        = ch_r;
    in_rng_nxt    = in_rng_r;
    res_nxt       = res_r;
    can_load      = !out_valid_r || !out_stall;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = hit_idx_r;
    ram_wdata     = {item_r.id, item_r.dim_w[DW-1:0], item_r.dim_h[DW-1:0]};
    match         = chk_v_r && valid_r[chk_idx_r] && (rd_id == item_r.id);
    is_last       = (chk_idx_r == LAST);
    needs_scan    = q.item.cls inside {CL_CREATE, CL_UNREF, CL_SCAN_ON, CL_FLUSH,
                                       CL_XFER, CL_ATTACH, CL_DETACH};
    after_scan    = (item_r.cls == CL_FLUSH || item_r.cls == CL_XFER) ? S_CLIP : S_DONE;
    ew            = 33'(hit_w_r);
    eh            = 33'(hit_h_r);
    sum_x         = {1'b0, item_r.x} + {1'b0, item_r.w};
    sum_y         = {1'b0, item_r.y} + {1'b0, item_r.h};

    case (state_r)
      S_IDLE: begin
        if (q.vld) begin
          item_nxt     = q.item;
          hit_nxt      = 1'b0;
          free_nxt     = 1'b0;
          scan_idx_nxt = '0;
          issue_nxt    = 1'b1;
          state_nxt    = needs_scan ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (issue_r) begin
          ram_re      = 1'b1;
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = scan_idx_r;
          if (scan_idx_r == LAST) issue_nxt = 1'b0;
          else scan_idx_nxt = scan_idx_r + IW'(1);
        end
        if (chk_v_r) begin
          if (!valid_r[chk_idx_r] && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = chk_idx_r;
          end
          if (match) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = chk_idx_r;
            hit_w_nxt   = rd_w;
            hit_h_nxt   = rd_h;
          end
          if (match || is_last) begin
            state_nxt = after_scan;
            issue_nxt = 1'b0;
            chk_v_nxt = 1'b0;
          end
        end
      end
      S_CLIP: begin
        // origin inside the resource, then cut the extent back to its edge
        in_rng_nxt = ({1'b0, item_r.x} < ew) && ({1'b0, item_r.y} < eh);
        cw_nxt = (sum_x > ew) ? DW'(ew - {1'b0, item_r.x}) : DW'(item_r.w);
        ch_nxt = (sum_y > eh) ? DW'(eh - {1'b0, item_r.y}) : DW'(item_r.h);
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (can_load) begin
          res_nxt          = '0;
          res_nxt.response = RSP_OK;
          res_nxt.fence    = item_r.fence;
          case (item_r.cls)
            CL_INFO: begin
              res_nxt.response = RSP_INFO;
              res_nxt.rep_w    = disp_w;
              res_nxt.rep_h    = disp_h;
            end
            CL_BADPARAM: res_nxt.response = RSP_BADPARAM;
            CL_UNSPEC:   res_nxt.response = RSP_UNSPEC;
            CL_CREATE: begin
              if (hit_r) begin
                ram_we = 1'b1;
              end else if (free_r) begin
                ram_we               = 1'b1;
                ram_waddr            = free_idx_r;
                valid_nxt[free_idx_r] = 1'b1;
              end else begin
                res_nxt.response = RSP_FULL;
              end
            end
            CL_UNREF: begin
              if (!hit_r) begin
                res_nxt.response = RSP_BADRES;
              end else begin
                if (so_res_r == item_r.id) so_res_nxt = '0;
                valid_nxt[hit_idx_r] = 1'b0;
              end
            end
            CL_SCAN_OFF: begin
              if (so_res_r != '0) res_nxt.ev = EV_DISABLED;
              so_res_nxt = '0;
              so_w_nxt   = '0;
              so_h_nxt   = '0;
            end
            CL_SCAN_ON: begin
              if (!hit_r) begin
                res_nxt.response = RSP_BADRES;
              end else begin
                so_res_nxt = item_r.id;
                so_w_nxt   = hit_w_r;
                so_h_nxt   = hit_h_r;
                if (so_res_r == '0 || hit_w_r != so_w_r || hit_h_r != so_h_r) begin
                  res_nxt.ev    = EV_ENABLED;
                  res_nxt.rep_w = REPORT_W'(hit_w_r);
                  res_nxt.rep_h = REPORT_W'(hit_h_r);
                end
              end
            end
            CL_FLUSH, CL_XFER: begin
              if (!hit_r) begin
                res_nxt.response = RSP_BADRES;
              end else if ((item_r.cls == CL_XFER || item_r.id == so_res_r) && in_rng_r) begin
                res_nxt.cx = item_r.x[CLIP_XY_W-1:0];
                res_nxt.cy = item_r.y[CLIP_XY_W-1:0];
                res_nxt.cw = CLIP_WH_W'(cw_r);
                res_nxt.ch = CLIP_WH_W'(ch_r);
                if (item_r.cls == CL_XFER) begin
                  res_nxt.kind = KIND_XFER;
                end else if (item_r.x == '0 && item_r.y == '0 &&
                             cw_r == hit_w_r && ch_r == hit_h_r) begin
                  res_nxt.kind = KIND_FULL;
                end else begin
                  res_nxt.kind = KIND_PARTIAL;
                end
              end
            end
            CL_ATTACH: begin
              if (!hit_r) res_nxt.response = RSP_BADRES;
              else if (item_r.cnt_over) res_nxt.response = RSP_BADPARAM;
            end
            CL_DETACH: begin
              if (!hit_r) res_nxt.response = RSP_BADRES;
            end
            CL_RESET: begin
              valid_nxt  = '0;
              so_res_nxt = '0;
              so_w_nxt   = '0;
              so_h_nxt   = '0;
            end
            default: res_nxt.response = RSP_UNSPEC;
          endcase
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      issue_r     <= 1'b0;
      chk_v_r     <= 1'b0;
      so_res_r    <= '0;
      so_w_r      <= '0;
      so_h_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      issue_r     <= issue_nxt;
      chk_v_r     <= chk_v_nxt;
      so_res_r    <= so_res_nxt;
      so_w_r      <= so_w_nxt;
      so_h_r      <= so_h_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    scan_idx_r <= scan_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    hit_r      <= hit_nxt;
    free_r     <= free_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    hit_w_r    <= hit_w_nxt;
    hit_h_r    <= hit_h_nxt;
    cw_r       <= cw_nxt;
    ch_r       <= ch_nxt;
    in_rng_r   <= in_rng_nxt;
    res_r      <= res_nxt;
  end

endmodule

### rtl/gst_checker.sv
// Port-level checks for the resource and scanout table, bound to the top level.
module gst_checker import gst_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [2:0]           out_response,
  input logic [REPORT_W-1:0]  out_report_width,
  input logic [CLIP_WH_W-1:0] out_clip_w,
  input logic [1:0]           out_region_kind,
  input logic [1:0]           out_scanout_event
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_response) && $stable(out_clip_w))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_region_kind != KIND_NONE |->
      out_response == RSP_OK && out_scanout_event == EV_NONE)
    else $error("region reported on a non-ok or scanout result");

  a_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_response != RSP_INFO && out_scanout_event == EV_NONE |->
      out_report_width == '0)
    else $error("size reported without info or scanout event");

endmodule

bind gpu_resource_scanout_table_top gst_checker u_gst_checker (.*);

### verif/tb_top.sv
// Testbench for the GPU resource and scanout table: a scoreboard predicts each response.
module tb_top;
  import gst_pkg::*;

  localparam int ENTRIES     = 64;
  localparam int DIM_LIMIT   = 16384;
  localparam int BACKING_MAX = 16384;
  localparam int DRAIN_WAIT  = ENTRIES + 16;   // worst table walk plus margin
  localparam int CYCLE_LIMIT = 1500000;
  localparam int RANDOM_CMDS = 1900;

  // One decoded control command as offered on the input channel.
  typedef struct {
    logic [3:0]  command;
    logic [31:0] id;
    logic [31:0] res_w;
    logic [31:0] res_h;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] scanout_idx;
    logic [31:0] entry_count;
    logic        fence;
    logic        short_req;
  } gpu_cmd_t;

  // Shadow copy of the resource table and scanout binding; expected responses queue here.
  class scanout_scoreboard;
    logic        slot_used [ENTRIES];
    logic [31:0] slot_id   [ENTRIES];
    logic [14:0] slot_w    [ENTRIES];
    logic [14:0] slot_h    [ENTRIES];
    logic [31:0] bound_id;
    logic [14:0] bound_w, bound_h;
    logic [14:0] disp_w, disp_h;
    gst_result_t pending_rsp[$];
    int          errors;
    int          cmds_seen;
    int          rsp_seen;

    function new();
      errors    = 0;
      cmds_seen = 0;
      rsp_seen  = 0;
      disp_w    = 15'd1024;
      disp_h    = 15'd768;
      clear_table();
    endfunction

    function void clear_table();
      for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
      bound_id = '0;
      bound_w  = '0;
      bound_h  = '0;
    endfunction

    function int lookup(logic [31:0] id);
      for (int i = 0; i < ENTRIES; i++)
        if (slot_used[i] && slot_id[i] == id) return i;
      return -1;
    endfunction

    // Predict the response of one accepted command and update the shadow state.
    function void note_command(gpu_cmd_t c);
      gst_result_t r;
      int          e;
      logic [32:0] ew, eh, cw, ch;
      r = '0;
      r.response = RSP_OK;
      r.fence    = c.fence;
      cmds_seen++;
      if (c.command >= CMD_CREATE && c.command <= CMD_DETACH && c.short_req) begin
        r.response = RSP_BADPARAM;
      end else begin
        case (c.command)
          CMD_INFO: begin
            r.response = RSP_INFO;
            r.rep_w    = disp_w;
            r.rep_h    = disp_h;
          end
          CMD_CREATE: begin
            if (c.id == 0 || c.res_w == 0 || c.res_h == 0 ||
                c.res_w > DIM_LIMIT || c.res_h > DIM_LIMIT) begin
              r.response = RSP_BADPARAM;
            end else begin
              e = lookup(c.id);
              if (e < 0)
                for (int i = ENTRIES - 1; i >= 0; i--)
                  if (!slot_used[i]) e = i;
              if (e < 0) begin
                r.response = RSP_FULL;
              end else begin
                slot_used[e] = 1'b1;
                slot_id[e]   = c.id;
                slot_w[e]    = c.res_w[14:0];
                slot_h[e]    = c.res_h[14:0];
              end
            end
          end
          CMD_UNREF: begin
            e = lookup(c.id);
            if (e < 0) begin
              r.response = RSP_BADRES;
            end else begin
              // binding is dropped but the remembered scanout size stays
              if (bound_id == c.id) bound_id = '0;
              slot_used[e] = 1'b0;
            end
          end
          CMD_SCANOUT: begin
            if (c.scanout_idx != 0) begin
              r.response = RSP_BADPARAM;
            end else if (c.id == 0) begin
              if (bound_id != 0) r.ev = EV_DISABLED;
              bound_id = '0;
              bound_w  = '0;
              bound_h  = '0;
            end else begin
              e = lookup(c.id);
              if (e < 0) begin
                r.response = RSP_BADRES;
              end else begin
                if (bound_id == 0 || slot_w[e] != bound_w || slot_h[e] != bound_h) begin
                  r.ev    = EV_ENABLED;
                  r.rep_w = slot_w[e];
                  r.rep_h = slot_h[e];
                end
                bound_id = c.id;
                bound_w  = slot_w[e];
                bound_h  = slot_h[e];
              end
            end
          end
          CMD_FLUSH, CMD_TRANSFER: begin
            e = lookup(c.id);
            if (e < 0) begin
              r.response = RSP_BADRES;
            end else if (c.command == CMD_TRANSFER || c.id == bound_id) begin
              ew = {18'd0, slot_w[e]};
              eh = {18'd0, slot_h[e]};
              if ({1'b0, c.x} < ew && {1'b0, c.y} < eh) begin
                cw = {1'b0, c.w};
                ch = {1'b0, c.h};
                if ({1'b0, c.x} + cw > ew) cw = ew - {1'b0, c.x};
                if ({1'b0, c.y} + ch > eh) ch = eh - {1'b0, c.y};
                r.cx = c.x[13:0];
                r.cy = c.y[13:0];
                r.cw = cw[14:0];
                r.ch = ch[14:0];
                if (c.command == CMD_TRANSFER)
                  r.kind = KIND_XFER;
                else if (c.x == 0 && c.y == 0 && cw == ew && ch == eh)
                  r.kind = KIND_FULL;
                else
                  r.kind = KIND_PARTIAL;
              end
            end
          end
          CMD_ATTACH: begin
            if (lookup(c.id) < 0) r.response = RSP_BADRES;
            else if (c.entry_count > BACKING_MAX) r.response = RSP_BADPARAM;
          end
          CMD_DETACH: begin
            if (lookup(c.id) < 0) r.response = RSP_BADRES;
          end
          CMD_RESET: clear_table();
          default: r.response = RSP_UNSPEC;
        endcase
      end
      pending_rsp.insert(pending_rsp.size(), r);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch on response %0d: %s got %0d expected %0d",
               $time, rsp_seen, what, got, want);
      errors++;
    endtask

    task check_response(gst_result_t got);
      gst_result_t want;
      rsp_seen++;
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected response, queue empty", got.response, -1);
      end else begin
        want = pending_rsp.pop_front();
        if (got.response != want.response) report_mismatch("response", got.response, want.response);
        if (got.fence != want.fence) report_mismatch("fence_echo", got.fence, want.fence);
        if (got.rep_w != want.rep_w) report_mismatch("report_width", got.rep_w, want.rep_w);
        if (got.rep_h != want.rep_h) report_mismatch("report_height", got.rep_h, want.rep_h);
        if (got.cx != want.cx) report_mismatch("clip_x", got.cx, want.cx);
        if (got.cy != want.cy) report_mismatch("clip_y", got.cy, want.cy);
        if (got.cw != want.cw) report_mismatch("clip_w", got.cw, want.cw);
        if (got.ch != want.ch) report_mismatch("clip_h", got.ch, want.ch);
        if (got.kind != want.kind) report_mismatch("region_kind", got.kind, want.kind);
        if (got.ev != want.ev) report_mismatch("scanout_event", got.ev, want.ev);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_command = '0;
  logic [31:0] in_resource_id = '0, in_res_width = '0, in_res_height = '0;
  logic [31:0] in_rect_x = '0, in_rect_y = '0, in_rect_w = '0, in_rect_h = '0;
  logic [31:0] in_scanout_index = '0, in_entry_count = '0;
  logic        in_fence_requested = 1'b0, in_request_short = 1'b0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           out_response;
  logic                 out_fence_echo;
  logic [REPORT_W-1:0]  out_report_width, out_report_height;
  logic [CLIP_XY_W-1:0] out_clip_x, out_clip_y;
  logic [CLIP_WH_W-1:0] out_clip_w, out_clip_h;
  logic [1:0]           out_region_kind, out_scanout_event;

  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  scanout_scoreboard sb = new();
  int  cycles = 0;
  bit  calm = 1'b0;        // no idling on either side while set
  bit  hold_out = 1'b0;    // receiver holds off for a long stretch
  int  cfg_writes = 0;

  gpu_resource_scanout_table_top #(
    .TABLE_ENTRIES(ENTRIES), .MAX_DIMENSION(DIM_LIMIT), .MAX_BACKING_ENTRIES(BACKING_MAX)
  ) DUT (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_command, .in_resource_id, .in_res_width, .in_res_height,
    .in_rect_x, .in_rect_y, .in_rect_w, .in_rect_h, .in_scanout_index, .in_entry_count,
    .in_fence_requested, .in_request_short,
    .out_valid, .out_stall, .out_response, .out_fence_echo, .out_report_width,
    .out_report_height, .out_clip_x, .out_clip_y, .out_clip_w, .out_clip_h,
    .out_region_kind, .out_scanout_event,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk = ~clk;

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses still owed",
               cycles, sb.pending_rsp.size());
      $display("status: fail");
      $finish;
    end
  end

  // Response side: stall pattern set at the falling edge, transfers checked at the rising edge.
  always @(negedge clk) begin
    if (hold_out) out_stall = 1'b1;
    else if (calm) out_stall = 1'b0;
    else out_stall = ($urandom_range(99) < 37);
  end

  always @(posedge clk) begin
    gst_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.response = out_response;
      got.fence    = out_fence_echo;
      got.rep_w    = out_report_width;
      got.rep_h    = out_report_height;
      got.cx       = out_clip_x;
      got.cy       = out_clip_y;
      got.cw       = out_clip_w;
      got.ch       = out_clip_h;
      got.kind     = out_region_kind;
      got.ev       = out_scanout_event;
      sb.check_response(got);
    end
  end

  // Offer one command; called at a falling edge and returns at a falling edge.
  task send_cmd(gpu_cmd_t c);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_command         = c.command;
    in_resource_id     = c.id;
    in_res_width       = c.res_w;
    in_res_height      = c.res_h;
    in_rect_x          = c.x;
    in_rect_y          = c.y;
    in_rect_w          = c.w;
    in_rect_h          = c.h;
    in_scanout_index   = c.scanout_idx;
    in_entry_count     = c.entry_count;
    in_fence_requested = c.fence;
    in_request_short   = c.short_req;
    in_valid           = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_command(c);
    @(negedge clk);
  endtask

  // Register write: setup cycle then access cycle.
  task write_reg(logic [2:0] addr, logic [31:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (addr == {REG_DISPLAY_WIDTH, 2'b00}) sb.disp_w = value[14:0];
    else sb.disp_h = value[14:0];
    cfg_writes++;
  endtask

  // Registers change only once every owed response has come back.
  task set_display(logic [31:0] w, logic [31:0] h);
    in_valid = 1'b0;
    while (sb.pending_rsp.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    write_reg({REG_DISPLAY_WIDTH, 2'b00}, w);
    write_reg({REG_DISPLAY_HEIGHT, 2'b00}, h);
  endtask

  function gpu_cmd_t make_cmd(logic [3:0] op, logic [31:0] id, logic [31:0] a = 0,
                              logic [31:0] b = 0, logic [31:0] x = 0, logic [31:0] y = 0,
                              logic [31:0] w = 0, logic [31:0] h = 0);
    gpu_cmd_t c;
    c.command     = op;
    c.id          = id;
    c.res_w       = a;
    c.res_h       = b;
    c.x           = x;
    c.y           = y;
    c.w           = w;
    c.h           = h;
    c.scanout_idx = 0;
    c.entry_count = 0;
    c.fence       = 1'($urandom_range(1));
    c.short_req   = 1'b0;
    return c;
  endfunction

  function logic [31:0] rand_dim();
    int p;
    p = $urandom_range(99);
    if (p < 70) return $urandom_range(1, 48);
    if (p < 78) return DIM_LIMIT;
    if (p < 84) return $urandom_range(1) ? 32'd0 : DIM_LIMIT + 1;
    if (p < 92) return $urandom_range(1, DIM_LIMIT);
    return $urandom;
  endfunction

  function logic [31:0] rand_coord();
    int p;
    p = $urandom_range(99);
    if (p < 70) return $urandom_range(0, 50);
    if (p < 85) return $urandom_range(0, DIM_LIMIT);
    return $urandom;
  endfunction

  // Mostly well-formed traffic over a small id pool so lookups hit and bindings move.
  function gpu_cmd_t rand_cmd();
    gpu_cmd_t c;
    int p;
    logic [3:0] op;
    p = $urandom_range(99);
    if (p < 25) op = CMD_CREATE;
    else if (p < 37) op = CMD_SCANOUT;
    else if (p < 52) op = CMD_FLUSH;
    else if (p < 66) op = CMD_TRANSFER;
    else if (p < 75) op = CMD_UNREF;
    else if (p < 83) op = CMD_ATTACH;
    else if (p < 89) op = CMD_DETACH;
    else if (p < 94) op = CMD_INFO;
    else if (p < 96) op = CMD_RESET;
    else op = 4'($urandom_range(CMD_RESET + 1, 15));
    c = make_cmd(op, 0, rand_dim(), rand_dim(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord());
    p = $urandom_range(99);
    if (p < 80) c.id = $urandom_range(1, 6);
    else if (p < 90) c.id = 0;
    else c.id = $urandom;
    c.scanout_idx = ($urandom_range(99) < 85) ? 32'd0 : $urandom;
    p = $urandom_range(99);
    if (p < 50) c.entry_count = $urandom_range(0, BACKING_MAX);
    else if (p < 70) c.entry_count = BACKING_MAX + $urandom_range(1);
    else c.entry_count = $urandom;
    c.short_req = ($urandom_range(99) < 8);
    return c;
  endfunction

  initial begin
    gpu_cmd_t c;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: edges of every command under the reset display size.
    send_cmd(make_cmd(CMD_INFO, 0));
    send_cmd(make_cmd(4'd9, 1));
    send_cmd(make_cmd(4'd15, 32'hFFFF_FFFF));
    send_cmd(make_cmd(CMD_CREATE, 0, 10, 10));               // id zero
    send_cmd(make_cmd(CMD_CREATE, 2, 0, 10));                // zero width
    send_cmd(make_cmd(CMD_CREATE, 2, 10, DIM_LIMIT + 1));    // too tall
    send_cmd(make_cmd(CMD_CREATE, 32'hFFFF_FFFF, DIM_LIMIT, DIM_LIMIT));
    send_cmd(make_cmd(CMD_CREATE, 1, 10, 10));
    c = make_cmd(CMD_CREATE, 3, 4, 4);
    c.short_req = 1'b1;                                       // short request
    send_cmd(c);
    c = make_cmd(CMD_SCANOUT, 1);
    c.scanout_idx = 32'hFFFF_FFFF;                            // bad scanout number
    send_cmd(c);
    send_cmd(make_cmd(CMD_SCANOUT, 1));                       // enable
    send_cmd(make_cmd(CMD_SCANOUT, 1));                       // same size, no event
    send_cmd(make_cmd(CMD_FLUSH, 1, 0, 0, 0, 0, 10, 10));    // full frame
    send_cmd(make_cmd(CMD_FLUSH, 1, 0, 0, 3, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_cmd(make_cmd(CMD_FLUSH, 1, 0, 0, 10, 0, 1, 1));     // origin outside
    send_cmd(make_cmd(CMD_FLUSH, 32'hFFFF_FFFF, 0, 0, 0, 0, 5, 5)); // not scanout
    send_cmd(make_cmd(CMD_TRANSFER, 32'hFFFF_FFFF, 0, 0, 16383, 16383, 9, 9));
    c = make_cmd(CMD_ATTACH, 1);
    c.entry_count = BACKING_MAX + 1;
    send_cmd(c);
    c.entry_count = BACKING_MAX;
    send_cmd(c);
    send_cmd(make_cmd(CMD_DETACH, 1));
    send_cmd(make_cmd(CMD_UNREF, 7));                         // missing id
    send_cmd(make_cmd(CMD_UNREF, 1));                         // drops the binding
    send_cmd(make_cmd(CMD_SCANOUT, 0));                       // nothing bound, no event
    send_cmd(make_cmd(CMD_RESET, 0));
    send_cmd(make_cmd(CMD_FLUSH, 32'hFFFF_FFFF));             // table was cleared

    // Fill the table past capacity, then clear it again.
    set_display(8, 1);
    for (int i = 0; i < ENTRIES + 6; i++)
      send_cmd(make_cmd(CMD_CREATE, 32'h100 + i * 32'h0101_0101, 1 + i, 2));
    send_cmd(make_cmd(CMD_INFO, 0));
    send_cmd(make_cmd(CMD_RESET, 0));

    // Random traffic in segments, each under its own display setting.
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: set_display(DIM_LIMIT, DIM_LIMIT);
        1: set_display(1024, 768);
        2: set_display(8 * $urandom_range(1, 2048), $urandom_range(1, DIM_LIMIT));
        3: set_display(8, DIM_LIMIT);
        4: set_display(DIM_LIMIT, 1);
        default: set_display(8 * $urandom_range(1, 2048), $urandom_range(1, DIM_LIMIT));
      endcase
      calm = (seg == 1);
      if (seg == 3) begin
        fork
          begin
            hold_out = 1'b1;
            repeat (400) @(negedge clk);
            hold_out = 1'b0;
          end
          for (int i = 0; i < RANDOM_CMDS / 6; i++) send_cmd(rand_cmd());
        join
      end else begin
        for (int i = 0; i < RANDOM_CMDS / 6; i++) send_cmd(rand_cmd());
      end
      calm = 1'b0;
    end
    in_valid = 1'b0;

    while (sb.pending_rsp.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (sb.pending_rsp.size() != 0)
      sb.report_mismatch("responses never delivered", 0, sb.pending_rsp.size());

    $display("covered %0d commands and %0d responses over %0d register writes",
             sb.cmds_seen, sb.rsp_seen, cfg_writes);
    $display("directed edges, table overflow, stalls with a long receiver hold-off");
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
